/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/lrnc_pkg.sv */
package lrnc_pkg;

    // Port widths
    localparam int LABEL_PORT_W  = 8;
    localparam int WIDTH_PORT_W  = 9;
    localparam int HEIGHT_PORT_W = 13;
    localparam int COUNT_W       = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 13;

    // Parameter defaults
    localparam int MAX_WIDTH_DEFAULT  = 256;
    localparam int LABEL_BITS_DEFAULT = 8;

    // Height limit and row counter width
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_W     = 13;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_LABEL = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [LABEL_PORT_W-1:0]  TARGET_RESET = 8'd1;
    localparam logic [WIDTH_PORT_W-1:0]  WIDTH_RESET  = 9'd20;
    localparam logic [HEIGHT_PORT_W-1:0] HEIGHT_RESET = 13'd20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

endpackage

/* design/lrnc_front.sv */
`include "assert_macros.svh"

module lrnc_front #(
    parameter int MAX_WIDTH  = lrnc_pkg::MAX_WIDTH_DEFAULT,
    parameter int LABEL_BITS = lrnc_pkg::LABEL_BITS_DEFAULT,
    parameter int ENTRY_W    = 2 * LABEL_BITS + 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lrnc_pkg::LABEL_PORT_W-1:0]    pixel_label,
    input  logic [lrnc_pkg::LABEL_PORT_W-1:0]    target_label,
    input  logic [lrnc_pkg::WIDTH_PORT_W-1:0]    frame_width,
    input  logic [lrnc_pkg::HEIGHT_PORT_W-1:0]   frame_height,
    output logic                                 q_push,
    output logic [ENTRY_W-1:0]                   q_data,
    input  logic                                 q_full
);
    import lrnc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > WIDTH_PORT_W) ? COL_W + 1 : WIDTH_PORT_W;

    typedef logic [LABEL_BITS-1:0] label_t;

    // Line buffer: previous row of labels
    label_t row_store [MAX_WIDTH];

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    label_t           left_reg, left_next;

    // Classify stage
    logic   s_valid_reg, s_valid_next;
    label_t s_here_reg;
    label_t s_left_reg;
    label_t s_up_reg;
    logic   s_has_up_reg;
    logic   s_has_left_reg;
    logic   s_last_reg;

    logic             accept;
    label_t           here;
    label_t           tgt;
    logic [CMP_W-1:0] w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W:0]   col_plus;
    logic [HEIGHT_W-1:0] row_plus;
    logic             end_row;
    logic             end_frame;

    logic   up_mark_v, left_mark_v;
    label_t up_mark, left_mark;

    // Pick the non-target side of a pair that has the target on one side only
    function automatic logic [LABEL_BITS:0] pair_mark(
        input label_t a,
        input label_t b,
        input label_t t,
        input logic   en
    );
        logic [LABEL_BITS:0] res;
        res = '0;
        if (en)
        begin
            if (a == t && b != t)
            begin
                res = {(b != '0), b};
            end
            else if (b == t && a != t)
            begin
                res = {(a != '0), a};
            end
        end
        return res;
    endfunction

    assign accept = in_valid && !in_stall;
    assign here   = label_t'(pixel_label);
    assign tgt    = label_t'(target_label);

    // Clamp frame geometry
    always_comb
    begin
        if (frame_width == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (CMP_W'(frame_width) > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CMP_W'(frame_width);
        end

        if (frame_height == '0)
        begin
            h_eff = HEIGHT_W'(1);
        end
        else if (frame_height > HEIGHT_W'(HEIGHT_LIMIT))
        begin
            h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = frame_height;
        end
    end

    assign col_plus  = {1'b0, col_reg} + 1'b1;
    assign row_plus  = {1'b0, row_reg} + 1'b1;
    assign end_row   = CMP_W'(col_plus) >= w_eff;
    assign end_frame = row_plus >= h_eff;

    // Advance raster position and left neighbor
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (accept)
        begin
            if (end_row)
            begin
                col_next  = '0;
                left_next = '0;
                row_next  = end_frame ? '0 : ROW_W'(row_plus);
            end
            else
            begin
                col_next  = COL_W'(col_plus);
                left_next = here;
            end
        end
    end

    // Hold a beat in the classify stage until the queue takes it
    assign q_push   = s_valid_reg && !q_full;
    assign in_stall = s_valid_reg && q_full;

    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (accept)
        begin
            s_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            left_reg    <= '0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            left_reg    <= left_next;
            s_valid_reg <= s_valid_next;
        end
    end

    // Read the pixel above and write the current one in the same beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_up_reg          <= row_store[col_reg];
            row_store[col_reg] <= here;
            s_here_reg        <= here;
            s_left_reg        <= left_reg;
            s_has_up_reg      <= (row_reg != '0);
            s_has_left_reg    <= (col_reg != '0);
            s_last_reg        <= end_row && end_frame;
        end
    end

    // Classify the two pairs of the staged pixel
    assign {up_mark_v, up_mark}     = pair_mark(s_here_reg, s_up_reg, tgt, s_has_up_reg);
    assign {left_mark_v, left_mark} = pair_mark(s_here_reg, s_left_reg, tgt, s_has_left_reg);

    assign q_data = {s_last_reg, left_mark_v, left_mark, up_mark_v, up_mark};

    `ASSERT_NEXT(a_row_wrap, clk, rst_n, accept && end_row, col_reg == '0)
    `ASSERT_NEXT(a_frame_wrap, clk, rst_n, accept && end_row && end_frame, row_reg == '0)

endmodule

/* design/lrnc_queue.sv */
`include "assert_macros.svh"

module lrnc_queue #(
    parameter int ENTRY_W = 2 * lrnc_pkg::LABEL_BITS_DEFAULT + 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_data,
    output logic               full,
    output logic               head_valid,
    output logic [ENTRY_W-1:0] head_data,
    input  logic               pop
);
    import lrnc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_W-1:0] slots [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = slots[rd_reg];
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill level
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store pushed beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_reg] <= push_data;
        end
    end

    `ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(QUEUE_DEPTH))

endmodule

/* design/lrnc_back.sv */
`include "assert_macros.svh"

module lrnc_back #(
    parameter int LABEL_BITS = lrnc_pkg::LABEL_BITS_DEFAULT,
    parameter int ENTRY_W    = 2 * LABEL_BITS + 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  logic [ENTRY_W-1:0]              q_data,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lrnc_pkg::COUNT_W-1:0]    neighbour_count
);
    import lrnc_pkg::*;

    localparam int LABEL_COUNT = 2 ** LABEL_BITS;

    typedef logic [LABEL_BITS-1:0] label_t;

    logic [LABEL_COUNT-1:0] seen_reg, seen_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]     out_count_reg;

    label_t           m0, m1;
    logic             m0_v, m1_v, last;
    logic             new0, new1;
    logic [COUNT_W:0] sum;
    logic [COUNT_W-1:0] total;
    logic             out_free;

    assign {last, m1_v, m1, m0_v, m0} = q_data;

    // Take a beat unless it ends a frame and the result slot is still full
    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = q_valid && (!last || out_free);

    // Count labels not yet seen; do not count a label twice in one beat
    assign new0  = m0_v && !seen_reg[m0];
    assign new1  = m1_v && !seen_reg[m1] && !(new0 && (m1 == m0));
    assign sum   = {1'b0, count_reg} + (COUNT_W + 1)'(new0) + (COUNT_W + 1)'(new1);
    assign total = (sum > (COUNT_W + 1)'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];

    always_comb
    begin
        seen_next      = seen_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (q_pop)
        begin
            if (last)
            begin
                seen_next      = '0;
                count_next     = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                if (new0)
                begin
                    seen_next[m0] = 1'b1;
                end
                if (new1)
                begin
                    seen_next[m1] = 1'b1;
                end
                count_next = total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result register at frame end
    always_ff @(posedge clk)
    begin
        if (q_pop && last)
        begin
            out_count_reg <= total;
        end
    end

    assign out_valid       = out_valid_reg;
    assign neighbour_count = out_count_reg;

    `ASSERT_NEXT(a_frame_clear, clk, rst_n, q_pop && last, count_reg == '0 && seen_reg == '0)
    `ASSERT_NEXT(a_count_grows, clk, rst_n, q_pop && !last, count_reg >= $past(count_reg))

endmodule

/* design/label_region_neighbour_count_unit.sv */
// The count appears on out_valid after the frame's last pixel is taken and passes through
// the classify stage and queue, when the queue is empty and the output register is free.
// Throughput: one pixel per cycle unless stalled; one line buffer read and write per pixel.
// One count per frame; the next frame's pixels flow on while a count waits.
// Reset: clears position, left label, seen bitmap, count, queue and output valid;
// the line buffer holds no reset value; what it reads on the first row is not used.
module label_region_neighbour_count_unit #(
    parameter int MAX_WIDTH  = lrnc_pkg::MAX_WIDTH_DEFAULT,
    parameter int LABEL_BITS = lrnc_pkg::LABEL_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lrnc_pkg::LABEL_PORT_W-1:0]   pixel_label,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lrnc_pkg::COUNT_W-1:0]        neighbour_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrnc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lrnc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lrnc_pkg::*;

    localparam int ENTRY_W = 2 * LABEL_BITS + 3;

    logic [LABEL_PORT_W-1:0]  target_reg;
    logic [WIDTH_PORT_W-1:0]  width_reg;
    logic [HEIGHT_PORT_W-1:0] height_reg;

    logic               q_push;
    logic [ENTRY_W-1:0] q_in;
    logic               q_full;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_head;
    logic               q_pop;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TARGET_LABEL: target_reg <= cfg_data[LABEL_PORT_W-1:0];
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[WIDTH_PORT_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[HEIGHT_PORT_W-1:0];
                default:          ;
            endcase
        end
    end

    lrnc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_label  (pixel_label),
        .target_label (target_reg),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .q_push       (q_push),
        .q_data       (q_in),
        .q_full       (q_full)
    );

    lrnc_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (q_head),
        .pop        (q_pop)
    );

    lrnc_back #(
        .LABEL_BITS (LABEL_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_data          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .neighbour_count (neighbour_count)
    );

endmodule
